// ===== rtl/cstk_pkg.sv =====
// Package for the circular cell stack: opcodes, default sizes and shared types.
package cstk_pkg;

  localparam int OP_W = 3;
  localparam int DATA_W = 32;

  localparam int DEPTH_DEF = 64;
  localparam int CELL_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_POP = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_AT = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Status of the result stage, handed from the controller to the top level.
  typedef struct packed {
    logic strobe;
    logic hit;
  } rsp_t;

endpackage

// ===== rtl/cstk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module cstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== rtl/cstk_ctrl.sv =====
// Stack controller: top pointer, per-cell valid bits, RAM addressing and result status.
module cstk_ctrl #(
  parameter int DEPTH = cstk_pkg::DEPTH_DEF,
  parameter int CELL_WIDTH = cstk_pkg::CELL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [cstk_pkg::OP_W-1:0]     op,
  input  logic [cstk_pkg::DATA_W-1:0]   value,
  input  logic [$clog2(DEPTH)-1:0]      index,
  output logic                          ram_we,
  output logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic [CELL_WIDTH-1:0]         ram_wdata,
  output logic [$clog2(DEPTH)-1:0]      ram_raddr,
  output logic [$clog2(DEPTH)-1:0]      ptr,
  output cstk_pkg::rsp_t                rsp
);
  import cstk_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [PW-1:0]    ptr_next;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] valid_next;
  logic             hit_next;

  // A cell with valid low reads as zero; pop and clear drop valid bits but keep RAM.
  always_comb begin
    ptr_next   = ptr;
    valid_next = valid;
    hit_next   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr + PW'(1);
    ram_wdata  = CELL_WIDTH'(value);
    ram_raddr  = ptr;
    if (accept) begin
      case (op)
        OP_PUSH: begin
          ptr_next             = ptr + PW'(1);
          ram_we               = 1'b1;
          valid_next[ram_waddr] = 1'b1;
        end
        OP_POP: begin
          hit_next        = valid[ptr];
          valid_next[ptr] = 1'b0;
          ptr_next        = ptr - PW'(1);
        end
        OP_PEEK: begin
          hit_next = valid[ptr];
        end
        OP_READ_AT: begin
          ram_raddr = index;
          hit_next  = (index < ptr) && valid[index];
        end
        OP_CLEAR: begin
          valid_next = '0;
          ptr_next   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      valid      <= '0;
      rsp.strobe <= 1'b0;
      rsp.hit    <= 1'b0;
    end else begin
      ptr        <= ptr_next;
      valid      <= valid_next;
      rsp.strobe <= accept;
      rsp.hit    <= hit_next;
    end
  end

endmodule

// ===== rtl/circular_cell_stack_top.sv =====
// Top level of the circular cell stack: controller plus cell RAM.
//
//   channel   handshake            payload
//   command   start / busy         op, value, index
//   result    done (one cycle)     data, depth
//
// A command is taken on any edge with start high; busy is always low.
// Its result appears with done in the next cycle, one result per command,
// so one command per cycle is sustained; the result comes from the
// registered read port of the single RAM.
// Reset clears the pointer and all cell valid bits at once, so every cell
// reads as zero after reset; clear does the same.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circular_cell_stack_top #(
  parameter int DEPTH = cstk_pkg::DEPTH_DEF,
  parameter int CELL_WIDTH = cstk_pkg::CELL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cstk_pkg::OP_W-1:0]     op,
  input  logic [cstk_pkg::DATA_W-1:0]   value,
  input  logic [$clog2(DEPTH)-1:0]      index,
  output logic                          done,
  output logic [cstk_pkg::DATA_W-1:0]   data,
  output logic [$clog2(DEPTH)-1:0]      depth
);
  import cstk_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic                  accept;
  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic [PW-1:0]         ram_raddr;
  logic [CELL_WIDTH-1:0] ram_rdata;
  rsp_t                  rsp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cstk_ctrl #(
    .DEPTH      (DEPTH),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .value     (value),
    .index     (index),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ptr       (depth),
    .rsp       (rsp)
  );

  cstk_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done = rsp.strobe;
  assign data = rsp.hit ? DATA_W'(ram_rdata) : '0;

  a_one_result_per_beat: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("command beat produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done)
    else $error("result without a command beat");

  a_push_advances: assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_PUSH) |=> (depth == PW'($past(depth) + PW'(1))) && (data == '0))
    else $error("push did not advance the pointer");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_CLEAR) |=> (depth == '0) && (data == '0))
    else $error("clear left the stack non-empty");

  a_read_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_READ_AT && index >= depth) |=> (data == '0))
    else $error("read beyond the pointer returned data");

endmodule
